@@ hw/rtl/pfa_pkg.sv @@
// Shared types, codes and constants of the prime field arithmetic unit.
package pfa_pkg;

  // Word width of operands, modulus and result.
  localparam int DATA_WIDTH = 8;

  // Modulus value after reset.
  localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = DATA_WIDTH'(7);

  // Operation codes carried by a command word.
  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  // Status codes carried by a response word.
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_DIV_ZERO   = 2'd1,
    STATUS_NO_INVERSE = 2'd2
  } status_t;

  // Command word.
  typedef struct packed {
    action_t               action;
    logic [DATA_WIDTH-1:0] operand_a;
    logic [DATA_WIDTH-1:0] operand_b;
  } cmd_t;

  // Response word.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] result;
    status_t               status;
  } rsp_t;

  // Operations of the shared modular adder.
  typedef enum logic {
    UNIT_ADD = 1'b0,
    UNIT_SUB = 1'b1
  } unit_op_t;

  // Control word from the sequencer to the shared modular adder.
  typedef struct packed {
    unit_op_t op;
    logic     cin;
  } unit_ctl_t;

endpackage

@@ hw/rtl/prime_field_alu.sv @@
// Operands are reduced one bit a cycle, a first and then b; add and subtract then finish
// in the execute state, which strobes done.
// Multiply then runs double-and-add over the multiplier bits, MSB first; divide runs a
// subtractive Euclid pass with a remainder step and a coefficient step per subtraction, then a multiply.
// Every step goes through the one shared modular adder; busy stays high until done,
// and a new word is taken in the done cycle. Synchronous reset sets the modulus to 7.
module prime_field_alu
  import pfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd,
  output logic                  done,
  output rsp_t                  rsp,
  input  logic                  modulus_we,
  input  logic [DATA_WIDTH-1:0] modulus_wdata
);

  localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_EXEC,
    S_MUL,
    S_INV_R,
    S_INV_T
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      cnt;
  action_t               action;
  logic [DATA_WIDTH-1:0] opa;
  logic [DATA_WIDTH-1:0] opb;
  logic [DATA_WIDTH-1:0] a_val;
  logic [DATA_WIDTH-1:0] b_val;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] mb;
  logic                  phase;
  logic [DATA_WIDTH-1:0] r0;
  logic [DATA_WIDTH-1:0] r1;
  logic [DATA_WIDTH-1:0] t0;
  logic [DATA_WIDTH-1:0] t1;
  logic [DATA_WIDTH-1:0] modulus;

  logic [DATA_WIDTH-1:0] p_eff;
  logic [DATA_WIDTH-1:0] u_x;
  logic [DATA_WIDTH-1:0] u_y;
  logic [DATA_WIDTH-1:0] u_m;
  unit_ctl_t             u_ctl;
  logic [DATA_WIDTH-1:0] u_sum;
  logic                  u_borrow;

  // A modulus below two behaves as one.
  assign p_eff = (modulus < DATA_WIDTH'(2)) ? DATA_WIDTH'(1) : modulus;

  assign busy = (state != S_IDLE);

  // Operand selection for the shared unit in each state.
  always_comb begin
    u_x   = acc;
    u_y   = acc;
    u_m   = p_eff;
    u_ctl = '{op: UNIT_ADD, cin: 1'b0};
    unique case (state)
      S_RED_A: u_ctl.cin = opa[DATA_WIDTH-1];
      S_RED_B: u_ctl.cin = opb[DATA_WIDTH-1];
      S_EXEC: begin
        u_x = a_val;
        u_y = b_val;
        if (action == ACT_SUB) begin
          u_ctl.op = UNIT_SUB;
        end
      end
      S_MUL: begin
        if (phase) begin
          u_y = a_val;
        end
      end
      S_INV_R: begin
        u_x      = r0;
        u_y      = r1;
        u_m      = '0;
        u_ctl.op = UNIT_SUB;
      end
      S_INV_T: begin
        u_x      = t0;
        u_y      = t1;
        u_ctl.op = UNIT_SUB;
      end
      default: begin
        u_x = acc;
      end
    endcase
  end

  pfa_mod_unit u_unit (
    .x      (u_x),
    .y      (u_y),
    .m      (u_m),
    .ctl    (u_ctl),
    .sum    (u_sum),
    .borrow (u_borrow)
  );

  // Sequencer, modulus register and response register.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state   <= S_IDLE;
      modulus <= MODULUS_RESET;
      phase   <= 1'b0;
    end else begin
      if (modulus_we) begin
        modulus <= modulus_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            action <= cmd.action;
            opa    <= cmd.operand_a;
            opb    <= cmd.operand_b;
            acc    <= '0;
            cnt    <= CNT_LAST;
            state  <= S_RED_A;
          end
        end
        // Reduce operand a MSB first: acc = 2*acc + bit mod p.
        S_RED_A: begin
          opa <= opa << 1;
          if (cnt == '0) begin
            a_val <= u_sum;
            acc   <= '0;
            cnt   <= CNT_LAST;
            state <= S_RED_B;
          end else begin
            acc <= u_sum;
            cnt <= cnt - 1'b1;
          end
        end
        S_RED_B: begin
          opb <= opb << 1;
          if (cnt == '0) begin
            b_val <= u_sum;
            acc   <= '0;
            state <= S_EXEC;
          end else begin
            acc <= u_sum;
            cnt <= cnt - 1'b1;
          end
        end
        // Add and subtract finish here; multiply and divide start their loops.
        S_EXEC: begin
          unique case (action) inside
            ACT_ADD, ACT_SUB: begin
              done       <= 1'b1;
              rsp.result <= u_sum;
              rsp.status <= STATUS_OK;
              state      <= S_IDLE;
            end
            ACT_MUL: begin
              mb    <= b_val;
              acc   <= '0;
              cnt   <= CNT_LAST;
              phase <= 1'b0;
              state <= S_MUL;
            end
            ACT_DIV: begin
              if (b_val == '0) begin
                done       <= 1'b1;
                rsp.result <= '0;
                rsp.status <= STATUS_DIV_ZERO;
                state      <= S_IDLE;
              end else begin
                r0    <= p_eff;
                r1    <= b_val;
                t0    <= '0;
                t1    <= DATA_WIDTH'(1);
                state <= S_INV_R;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        // Double-and-add over the multiplier bits, MSB first.
        S_MUL: begin
          acc <= u_sum;
          if (!phase && mb[DATA_WIDTH-1]) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            mb    <= mb << 1;
            if (cnt == '0) begin
              done       <= 1'b1;
              rsp.result <= u_sum;
              rsp.status <= STATUS_OK;
              state      <= S_IDLE;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
        end
        // Subtractive Euclid on the remainders; swap the pairs when r0 < r1.
        S_INV_R: begin
          if (r1 == '0) begin
            if (r0 == DATA_WIDTH'(1)) begin
              mb    <= t0;
              acc   <= '0;
              cnt   <= CNT_LAST;
              phase <= 1'b0;
              state <= S_MUL;
            end else begin
              done       <= 1'b1;
              rsp.result <= '0;
              rsp.status <= STATUS_NO_INVERSE;
              state      <= S_IDLE;
            end
          end else if (u_borrow) begin
            r0 <= r1;
            r1 <= r0;
            t0 <= t1;
            t1 <= t0;
          end else begin
            r0    <= u_sum;
            state <= S_INV_T;
          end
        end
        // Matching coefficient update: t0 = t0 - t1 mod p.
        S_INV_T: begin
          t0    <= u_sum;
          state <= S_INV_R;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/pfa_mod_unit.sv @@
// Shared modular adder/subtractor with a single correction step.
module pfa_mod_unit
  import pfa_pkg::*;
(
  input  logic [DATA_WIDTH-1:0] x,
  input  logic [DATA_WIDTH-1:0] y,
  input  logic [DATA_WIDTH-1:0] m,
  input  unit_ctl_t             ctl,
  output logic [DATA_WIDTH-1:0] sum,
  output logic                  borrow
);

  logic [DATA_WIDTH:0] raw;

  // Add: x + y + cin, minus m once if the sum reaches m.
  // Subtract: x - y, plus m once if it went negative (m of zero gives the raw difference).
  always_comb begin
    raw    = '0;
    sum    = '0;
    borrow = 1'b0;
    unique case (ctl.op)
      UNIT_ADD: begin
        raw = {1'b0, x} + {1'b0, y} + {{DATA_WIDTH{1'b0}}, ctl.cin};
        if (raw >= {1'b0, m}) begin
          sum = raw[DATA_WIDTH-1:0] - m;
        end else begin
          sum = raw[DATA_WIDTH-1:0];
        end
      end
      UNIT_SUB: begin
        raw    = {1'b0, x} - {1'b0, y};
        borrow = raw[DATA_WIDTH];
        if (borrow) begin
          sum = raw[DATA_WIDTH-1:0] + m;
        end else begin
          sum = raw[DATA_WIDTH-1:0];
        end
      end
      default: begin
        sum = raw[DATA_WIDTH-1:0];
      end
    endcase
  end

endmodule

@@ hw/rtl/pfa_checker.sv @@
// Port-level checks of the prime field arithmetic unit, bound to the top level.
module pfa_checker
  import pfa_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  // The cycle after reset the unit is idle with no word out.
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("unit not idle after reset");

  // An accepted command keeps the unit busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command accepted but unit not busy");

  // A response word comes with the unit already free.
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("response while busy");

  // Each response strobe lasts one cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("response strobe repeated");

  // Error responses carry a zero result.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != STATUS_OK |-> rsp.result == '0)
    else $error("error response with nonzero result");

endmodule

bind prime_field_alu pfa_checker u_pfa_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
